### rtl/tar_pkg.sv
package tar_pkg;

   localparam int NUM_AXES    = 4;
   localparam int MAX_RANK    = 4;
   localparam int ELEM_W      = 64;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANK  = 3'd0,
      CSR_SIZE0 = 3'd1,
      CSR_SIZE1 = 3'd2,
      CSR_SIZE2 = 3'd3,
      CSR_SIZE3 = 3'd4,
      CSR_AXIS  = 3'd5
   } csr_index_type;

   // per-element control that travels from the front to the back
   typedef struct packed {
      logic first;   // reduced coordinate is zero: start a new sum
      logic last;    // reduced coordinate at its top: emit the sum
      logic done;    // last element of the whole tensor
      logic err;     // inner extent product exceeds the accumulator
   } flags_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_UNPACK,
      BK_ALIGN,
      BK_NORM,
      BK_ROUND
   } back_state_type;

endpackage

### rtl/tar_if.sv
interface tar_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] element_bits;

   modport source (output valid, output element_bits, input ready);
   modport sink   (input valid, input element_bits, output ready);
endinterface

interface tar_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] sum_bits;
   logic        final_result;
   logic        depth_error;

   modport source (output valid, output sum_bits, output final_result, output depth_error,
                   input ready);
   modport sink   (input valid, input sum_bits, input final_result, input depth_error,
                   output ready);
endinterface

### rtl/tensor_axis_reduce_sum.sv
// Channel   | Direction | Transaction payload
// ----------+-----------+----------------------------------------------------
// req_chan  | in        | element_bits: one binary64 element, axis 0 fastest
// rsp_chan  | out       | sum_bits, final_result, depth_error
// csr_*     | in        | csr_index, csr_wdata: write-only register port
//
// Each element occupies the accumulator loop for one memory read, then unpack,
// align/add, normalize and round/write-back of the binary64 adder. The front
// accepts one transaction per cycle while its four-entry queue has room.
// Reset is synchronous; it restores rank 1, all extents 1, reduce axis 0.
// A write to a known register restarts the tensor; any write holds ready low.
// A stalled result waits in the output register while the next element runs.
module tensor_axis_reduce_sum #(
   parameter int ACC_DEPTH = 4096,
   parameter int DIM_BITS  = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   tar_req_if.sink                         req_chan,
   tar_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [tar_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tar_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tar_pkg::*;

   localparam int ADDR_W  = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   localparam int FLAGS_W = $bits(flags_type);
   localparam int QW      = ELEM_W + ADDR_W + FLAGS_W;

   // front to queue
   logic              push_valid, push_ready;
   logic [ELEM_W-1:0] push_element;
   logic [ADDR_W-1:0] push_slot;
   flags_type         push_flags;
   // queue to back
   logic              pop_valid, pop_ready;
   logic [QW-1:0]     pop_data;
   logic [ELEM_W-1:0] pop_element;
   logic [ADDR_W-1:0] pop_slot;
   flags_type         pop_flags;

   // coordinate tracking, slot addressing and the depth check
   tar_front #(
      .ACC_DEPTH (ACC_DEPTH),
      .DIM_BITS  (DIM_BITS),
      .ADDR_W    (ADDR_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_element (push_element),
      .push_slot    (push_slot),
      .push_flags   (push_flags)
   );

   // decouple classification from the accumulate loop
   tar_queue #(
      .WIDTH (QW),
      .DEPTH (4)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_element, push_slot, push_flags}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_element = pop_data[QW-1 -: ELEM_W];
   assign pop_slot    = pop_data[FLAGS_W +: ADDR_W];
   assign pop_flags   = flags_type'(pop_data[FLAGS_W-1:0]);

   // read-add-write on the partial sum memory, result register
   tar_back #(
      .ACC_DEPTH (ACC_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_element (pop_element),
      .pop_slot    (pop_slot),
      .pop_flags   (pop_flags),
      .rsp_chan    (rsp_chan)
   );

`ifndef SYNTHESIS
   // every accepted element lands in the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (push_valid && push_ready))
      else $error("accepted element not queued");

   // the back takes one element at a time
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> !pop_ready)
      else $error("back popped while busy");

   // a register write blocks input while the depth check settles
   assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_chan.ready)
      else $error("input open right after register write");
`endif

endmodule

### rtl/tar_front.sv
module tar_front #(
   parameter int ACC_DEPTH = 4096,
   parameter int DIM_BITS  = 12,
   parameter int ADDR_W    = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tar_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tar_pkg::CSR_DATA_W-1:0]  csr_wdata,
   tar_req_if.sink                         req_chan,
   output logic                            push_valid,
   input  logic                            push_ready,
   output logic [tar_pkg::ELEM_W-1:0]      push_element,
   output logic [ADDR_W-1:0]               push_slot,
   output tar_pkg::flags_type              push_flags
);
   import tar_pkg::*;

   localparam int SZ_W  = DIM_BITS + 1;
   localparam int CMP_W = (SZ_W > CSR_DATA_W) ? SZ_W : CSR_DATA_W;
   localparam logic [CMP_W-1:0] SZ_TOP = CMP_W'(1) << DIM_BITS;
   localparam logic [63:0] DEPTH64 = 64'(ACC_DEPTH);
   localparam logic [1:0] SETTLE = 2'd2;

   logic [2:0]            rank_ff;
   logic [CSR_DATA_W-1:0] size_ff [NUM_AXES];
   logic [1:0]            axis_ff;
   logic [DIM_BITS-1:0]   coord_ff [NUM_AXES];
   logic [DIM_BITS-1:0]   coord_in [NUM_AXES];
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [2*SZ_W-1:0]     p01_ff, p01_in;
   logic                  err_ff, err_in;
   logic [1:0]            settle_ff, settle_in;

   logic [2:0]            rank_eff;
   logic [SZ_W-1:0]       sz [NUM_AXES];
   logic [NUM_AXES-1:0]   at_top;
   logic [NUM_AXES:0]     carry;
   logic [3*SZ_W-1:0]     p012;
   logic                  cfg_hit;
   logic                  fire;

   // effective extents from the registers
   always_comb begin
      logic [CMP_W-1:0] raw;
      rank_eff = rank_ff;
      if (rank_eff == 3'd0) begin
         rank_eff = 3'd1;
      end
      if (rank_eff > 3'(MAX_RANK)) begin
         rank_eff = 3'(MAX_RANK);
      end
      for (int d = 0; d < NUM_AXES; d++) begin
         raw = CMP_W'(size_ff[d]);
         if (3'(d) >= rank_eff) begin
            sz[d] = SZ_W'(1);
         end else if (raw == '0) begin
            sz[d] = SZ_W'(1);
         end else if (raw > SZ_TOP) begin
            sz[d] = SZ_W'(SZ_TOP);
         end else begin
            sz[d] = SZ_W'(raw);
         end
      end
   end

   // odometer step over the four coordinates, axis 0 fastest
   always_comb begin
      carry[0] = 1'b1;
      for (int d = 0; d < NUM_AXES; d++) begin
         at_top[d]   = {1'b0, coord_ff[d]} >= (sz[d] - SZ_W'(1));
         carry[d+1]  = carry[d] & at_top[d];
         if (!carry[d]) begin
            coord_in[d] = coord_ff[d];
         end else if (at_top[d]) begin
            coord_in[d] = '0;
         end else begin
            coord_in[d] = coord_ff[d] + DIM_BITS'(1);
         end
      end
      // slot returns to zero when the carry reaches the reduced axis or at the top slot
      if (carry[axis_ff]) begin
         slot_in = '0;
      end else if (slot_ff == ADDR_W'(ACC_DEPTH - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + ADDR_W'(1);
      end
   end

   // depth check over two registered steps
   always_comb begin
      p01_in = sz[0] * sz[1];
      p012   = p01_ff * sz[2];
      unique case (axis_ff)
         2'd0:    err_in = 1'b0;
         2'd1:    err_in = 64'(sz[0]) > DEPTH64;
         2'd2:    err_in = 64'(p01_ff) > DEPTH64;
         default: err_in = 64'(p012) > DEPTH64;
      endcase
   end

   assign cfg_hit = csr_we && (csr_index == CSR_RANK  || csr_index == CSR_SIZE0 ||
                               csr_index == CSR_SIZE1 || csr_index == CSR_SIZE2 ||
                               csr_index == CSR_SIZE3 || csr_index == CSR_AXIS);
   assign settle_in = csr_we ? SETTLE : ((settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0);

   assign push_valid     = req_chan.valid && (settle_ff == 2'd0);
   assign req_chan.ready = push_ready && (settle_ff == 2'd0);
   assign fire           = req_chan.valid && req_chan.ready;

   assign push_element     = req_chan.element_bits;
   assign push_slot        = slot_ff;
   assign push_flags.first = (coord_ff[axis_ff] == '0);
   assign push_flags.last  = at_top[axis_ff];
   assign push_flags.done  = carry[NUM_AXES];
   assign push_flags.err   = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff   <= 3'd1;
         axis_ff   <= 2'd0;
         settle_ff <= SETTLE;
         slot_ff   <= '0;
         p01_ff    <= '0;
         err_ff    <= 1'b0;
         for (int d = 0; d < NUM_AXES; d++) begin
            size_ff[d]  <= CSR_DATA_W'(1);
            coord_ff[d] <= '0;
         end
      end else begin
         settle_ff <= settle_in;
         p01_ff    <= p01_in;
         err_ff    <= err_in;
         if (cfg_hit) begin
            unique case (csr_index)
               CSR_RANK:  rank_ff    <= csr_wdata[2:0];
               CSR_SIZE0: size_ff[0] <= csr_wdata;
               CSR_SIZE1: size_ff[1] <= csr_wdata;
               CSR_SIZE2: size_ff[2] <= csr_wdata;
               CSR_SIZE3: size_ff[3] <= csr_wdata;
               default:   axis_ff    <= csr_wdata[1:0];
            endcase
            slot_ff <= '0;
            for (int d = 0; d < NUM_AXES; d++) begin
               coord_ff[d] <= '0;
            end
         end else if (fire) begin
            slot_ff <= slot_in;
            for (int d = 0; d < NUM_AXES; d++) begin
               coord_ff[d] <= coord_in[d];
            end
         end
      end
   end

endmodule

### rtl/tar_queue.sv
module tar_queue #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_q [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push_fire, pop_fire;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_q[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_q[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

### rtl/tar_back.sv
module tar_back #(
   parameter int ACC_DEPTH = 4096,
   parameter int ADDR_W    = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  logic [tar_pkg::ELEM_W-1:0] pop_element,
   input  logic [ADDR_W-1:0]          pop_slot,
   input  tar_pkg::flags_type         pop_flags,
   tar_rsp_if.source                  rsp_chan
);
   import tar_pkg::*;

   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
   localparam logic [10:0] EXP_MAX     = 11'h7FF;

   function automatic logic [5:0] lzc56(input logic [55:0] v);
      logic [63:0] w;
      logic [5:0]  n;
      w = {v, 8'hFF};
      n = '0;
      if (w[63:32] == '0) begin n = n + 6'd32; w = w << 32; end
      if (w[63:48] == '0) begin n = n + 6'd16; w = w << 16; end
      if (w[63:56] == '0) begin n = n + 6'd8;  w = w << 8;  end
      if (w[63:60] == '0) begin n = n + 6'd4;  w = w << 4;  end
      if (w[63:62] == '0) begin n = n + 6'd2;  w = w << 2;  end
      if (w[63] == 1'b0)  begin n = n + 6'd1; end
      return n;
   endfunction

   back_state_type state_ff, state_in;

   logic [63:0]       acc_mem [ACC_DEPTH];
   logic [63:0]       rd_data_ff;
   logic [63:0]       elem_ff;
   logic [ADDR_W-1:0] slot_ff;
   flags_type         flags_ff;

   // adder pipeline registers
   logic        sign_ff, sub_ff, spec_ff, zero_ff;
   logic [63:0] specv_ff;
   logic [10:0] exp_ff, diff_ff;
   logic [52:0] mbig_ff, msml_ff;
   logic [56:0] sum_ff;
   logic [55:0] norm_ff;
   logic [11:0] ne_ff;
   logic [5:0]  sh_ff;

   logic        rsp_valid_ff, rsp_final_ff, rsp_err_ff;
   logic [63:0] rsp_sum_ff;

   logic        pop_fire, advance, wr_en, rsp_load;

   // unpack and order operands
   logic [63:0] opa, opb, big, sml, specv;
   logic        a_nan, b_nan, a_inf, b_inf, spec;
   logic [10:0] ebig, esml;
   // align and add
   logic [55:0] m2_shift, m2_mask, m2_sticky;
   logic [56:0] sum;
   // normalize
   logic [55:0] norm;
   logic [11:0] ne;
   logic [5:0]  lz, sh;
   logic [10:0] emax;
   // round and pack
   logic [55:0] mfin;
   logic [11:0] e2;
   logic [10:0] field;
   logic        rnd;
   logic [62:0] packed_mag;
   logic [63:0] result;

   always_comb begin
      opa   = flags_ff.first ? 64'h0 : rd_data_ff;
      opb   = elem_ff;
      a_nan = (opa[62:52] == EXP_MAX) && (opa[51:0] != '0);
      b_nan = (opb[62:52] == EXP_MAX) && (opb[51:0] != '0);
      a_inf = (opa[62:52] == EXP_MAX) && (opa[51:0] == '0);
      b_inf = (opb[62:52] == EXP_MAX) && (opb[51:0] == '0);
      spec  = (opa[62:52] == EXP_MAX) || (opb[62:52] == EXP_MAX);
      priority if (a_nan) begin
         specv = opa | QUIET_BIT;
      end else if (b_nan) begin
         specv = opb | QUIET_BIT;
      end else if (a_inf && b_inf && (opa[63] != opb[63])) begin
         specv = DEFAULT_NAN;
      end else if (a_inf) begin
         specv = opa;
      end else begin
         specv = opb;
      end
      if (opa[62:0] >= opb[62:0]) begin
         big = opa;
         sml = opb;
      end else begin
         big = opb;
         sml = opa;
      end
      ebig = (big[62:52] == '0) ? 11'd1 : big[62:52];
      esml = (sml[62:52] == '0) ? 11'd1 : sml[62:52];
   end

   always_comb begin
      m2_shift  = {msml_ff, 3'b000} >> diff_ff;
      m2_mask   = ~({56{1'b1}} << diff_ff);
      m2_sticky = m2_shift | {55'b0, |({msml_ff, 3'b000} & m2_mask)};
      if (sub_ff) begin
         sum = {1'b0, mbig_ff, 3'b000} - {1'b0, m2_sticky};
      end else begin
         sum = {1'b0, mbig_ff, 3'b000} + {1'b0, m2_sticky};
      end
   end

   always_comb begin
      lz   = lzc56(sum_ff[55:0]);
      emax = exp_ff - 11'd1;
      if (sum_ff[56]) begin
         norm = {sum_ff[56:2], sum_ff[1] | sum_ff[0]};
         ne   = {1'b0, exp_ff} + 12'd1;
         sh   = '0;
      end else begin
         norm = sum_ff[55:0];
         ne   = {1'b0, exp_ff};
         sh   = (emax < 11'(lz)) ? 6'(emax) : lz;
      end
   end

   always_comb begin
      mfin       = norm_ff << sh_ff;
      e2         = ne_ff - 12'(sh_ff);
      field      = mfin[55] ? 11'(e2) : 11'd0;
      rnd        = mfin[2] & (mfin[3] | mfin[1] | mfin[0]);
      packed_mag = {field, mfin[54:3]} + 63'(rnd);
      priority if (spec_ff) begin
         result = specv_ff;
      end else if (zero_ff) begin
         result = {sign_ff & ~sub_ff, 63'b0};
      end else if (e2 >= 12'(EXP_MAX)) begin
         result = {sign_ff, EXP_MAX, 52'b0};
      end else begin
         result = {sign_ff, packed_mag};
      end
   end

   // sequencer: one element at a time through read, add, write back
   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      advance   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = BK_UNPACK;
            end
         end
         BK_UNPACK: state_in = BK_ALIGN;
         BK_ALIGN:  state_in = BK_NORM;
         BK_NORM:   state_in = BK_ROUND;
         BK_ROUND: begin
            advance = !flags_ff.last || !rsp_valid_ff || rsp_chan.ready;
            if (advance) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign pop_fire = pop_valid && pop_ready;
   assign wr_en    = advance;
   assign rsp_load = advance && flags_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         rd_data_ff <= acc_mem[pop_slot];
      end
      if (wr_en) begin
         acc_mem[slot_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         elem_ff  <= pop_element;
         slot_ff  <= pop_slot;
         flags_ff <= pop_flags;
      end
      if (state_ff == BK_UNPACK) begin
         sign_ff  <= big[63];
         sub_ff   <= opa[63] ^ opb[63];
         spec_ff  <= spec;
         specv_ff <= specv;
         exp_ff   <= ebig;
         diff_ff  <= ebig - esml;
         mbig_ff  <= {big[62:52] != '0, big[51:0]};
         msml_ff  <= {sml[62:52] != '0, sml[51:0]};
      end
      if (state_ff == BK_ALIGN) begin
         sum_ff <= sum;
      end
      if (state_ff == BK_NORM) begin
         norm_ff <= norm;
         ne_ff   <= ne;
         sh_ff   <= sh;
         zero_ff <= (sum_ff == '0);
      end
   end

   // output register: holds a finished sum while the next element runs
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_chan.ready);
      end
      if (rsp_load) begin
         rsp_sum_ff   <= result;
         rsp_final_ff <= flags_ff.done;
         rsp_err_ff   <= flags_ff.err;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sum_bits     = rsp_sum_ff;
   assign rsp_chan.final_result = rsp_final_ff;
   assign rsp_chan.depth_error  = rsp_err_ff;

endmodule

### sim/tensor_axis_reduce_sum_test.sv
module tensor_axis_reduce_sum_test;
   import tar_pkg::*;

   // Index past the register list: a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_NONE = 3'd7;
   localparam int ACC_SLOTS     = 4096;
   localparam int TOP_EXTENT    = 4096;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT   = 2000000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tar_req_if req_chan ();
   tar_rsp_if rsp_chan ();

   tensor_axis_reduce_sum dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   typedef struct packed {
      logic [63:0] sum_bits;
      logic        final_result;
      logic        depth_error;
   } tensor_sum_type;

   // Shadow copy of the register file and of the element position.
   logic [2:0]  shape_rank;
   logic [12:0] shape_extent [4];
   logic [1:0]  shape_axis;
   int unsigned elem_pos [4];
   logic [63:0] acc_sums [ACC_SLOTS];

   logic [63:0]    pending_elements [$];
   tensor_sum_type sums_due [$];

   int  error_count;
   int  cycle_count;
   int  send_gap;
   int  take_gap;
   bit  quiet;

   // Free-running clock, 20 time units per period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   // Effective extent of one dimension, clamped as the block does.
   function automatic int unsigned extent_of(input int d, input int unsigned rank);
      int unsigned s;
      if (d >= rank) return 1;
      s = shape_extent[d];
      if (s == 0) s = 1;
      if (s > TOP_EXTENT) s = TOP_EXTENT;
      return s;
   endfunction

   // Fold one accepted element into the running sums; queue a result when the
   // reduced coordinate reaches its top.
   task automatic accumulate_element(input logic [63:0] element);
      int unsigned rank;
      int unsigned ext [4];
      int unsigned axis;
      longint unsigned offset;
      longint unsigned stride;
      int unsigned slot;
      bit overflow;
      bit closing;
      bit tensor_done;
      real total;
      tensor_sum_type r;
      rank = shape_rank;
      if (rank < 1) rank = 1;
      if (rank > MAX_RANK) rank = MAX_RANK;
      axis = shape_axis;
      offset = 0;
      stride = 1;
      for (int d = 0; d < 4; d++) ext[d] = extent_of(d, rank);
      for (int d = 0; d < axis; d++) begin
         offset += elem_pos[d] * stride;
         stride *= ext[d];
      end
      overflow = stride > ACC_SLOTS;
      slot = offset % ACC_SLOTS;
      if (elem_pos[axis] == 0) total = 0.0 + $bitstoreal(element);
      else total = $bitstoreal(acc_sums[slot]) + $bitstoreal(element);
      acc_sums[slot] = $realtobits(total);
      closing = elem_pos[axis] >= ext[axis] - 1;
      // advance the position, axis 0 fastest
      tensor_done = 1'b1;
      for (int d = 0; d < 4; d++) begin
         if (elem_pos[d] >= ext[d] - 1) begin
            elem_pos[d] = 0;
         end else begin
            elem_pos[d]++;
            tensor_done = 1'b0;
            break;
         end
      end
      if (closing) begin
         r.sum_bits     = $realtobits(total);
         r.final_result = tensor_done;
         r.depth_error  = overflow;
         sums_due = {sums_due, r};
      end
   endtask

   // Driver: present pending elements, with random gaps unless quiet.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_chan.valid        <= 1'b0;
         req_chan.element_bits <= '0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) accumulate_element(req_chan.element_bits);
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_elements.size() > 0) begin
               req_chan.valid        <= 1'b1;
               req_chan.element_bits <= pending_elements.pop_front();
               if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: take results with random stalls, check against the oldest sum due.
   always @(posedge clock) begin
      tensor_sum_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (sums_due.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_chan.sum_bits, '0);
            end else begin
               want = sums_due.pop_front();
               if (rsp_chan.sum_bits !== want.sum_bits)
                  report_mismatch("sum_bits", rsp_chan.sum_bits, want.sum_bits);
               if (rsp_chan.final_result !== want.final_result)
                  report_mismatch("final_result", 64'(rsp_chan.final_result),
                                  64'(want.final_result));
               if (rsp_chan.depth_error !== want.depth_error)
                  report_mismatch("depth_error", 64'(rsp_chan.depth_error),
                                  64'(want.depth_error));
            end
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 4) == 0) take_gap = $urandom_range(1, 4);
         end
      end
   end

   // Hard stop on a hang.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Hold until every element has gone in and every sum has come out, then let
   // the accumulator loop drain elements that produce no result.
   task automatic wait_idle();
      while (pending_elements.size() > 0 || req_chan.valid || sums_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      case (idx)
         CSR_RANK:  shape_rank <= val[2:0];
         CSR_SIZE0: shape_extent[0] <= val[12:0];
         CSR_SIZE1: shape_extent[1] <= val[12:0];
         CSR_SIZE2: shape_extent[2] <= val[12:0];
         CSR_SIZE3: shape_extent[3] <= val[12:0];
         CSR_AXIS:  shape_axis <= val[1:0];
         default: ;
      endcase
      if (idx <= CSR_AXIS) for (int d = 0; d < 4; d++) elem_pos[d] = 0;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_shape(input int unsigned rank, input int unsigned s0,
                            input int unsigned s1, input int unsigned s2,
                            input int unsigned s3, input int unsigned axis);
      wait_idle();
      csr_write(CSR_RANK, rank);
      csr_write(CSR_SIZE0, s0);
      csr_write(CSR_SIZE1, s1);
      csr_write(CSR_SIZE2, s2);
      csr_write(CSR_SIZE3, s3);
      csr_write(CSR_AXIS, axis);
   endtask

   // Mostly ordinary magnitudes for sane sums; the rest raw or edge patterns.
   function automatic logic [63:0] pick_element();
      logic [63:0] edges [8];
      edges = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
                64'h0000_0000_0000_0001, 64'h7FF8_0000_0000_0000};
      case ($urandom_range(0, 9))
         7:       return {$urandom, $urandom};
         8:       return edges[$urandom_range(0, 7)];
         9:       return {$urandom_range(0, 1) == 1, 11'h000, 20'($urandom), $urandom};
         default: return {$urandom_range(0, 1) == 1, 11'($urandom_range(1013, 1033)),
                          20'($urandom), $urandom};
      endcase
   endfunction

   // Append one element to the pending list.
   task automatic add_element(input logic [63:0] element);
      pending_elements = {pending_elements, element};
   endtask

   task automatic push_elements(input int count);
      for (int i = 0; i < count; i++) add_element(pick_element());
   endtask

   initial begin
      int unsigned rank;
      int unsigned ext [4];
      int unsigned axis;
      int unsigned volume;
      int sent;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = CSR_RANK;
      csr_wdata   = '0;
      req_chan.valid        = 1'b0;
      req_chan.element_bits = '0;
      rsp_chan.ready        = 1'b0;
      error_count = 0;
      cycle_count = 0;
      quiet       = 1'b0;
      shape_rank  = 3'd1;
      shape_axis  = 2'd0;
      for (int d = 0; d < 4; d++) begin
         shape_extent[d] = 13'd1;
         elem_pos[d]     = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset shape: every element is its own sum; negative zero comes back as +0.
      add_element(64'h8000_0000_0000_0000);
      add_element(64'h7FF8_0000_0000_0001);

      // Vector sums: -0 + -0, inf - inf, overflow to inf, denormals.
      set_shape(1, 3, 1, 1, 1, 0);
      add_element(64'h8000_0000_0000_0000);
      add_element(64'h8000_0000_0000_0000);
      add_element(64'h8000_0000_0000_0000);
      add_element(64'h7FF0_0000_0000_0000);
      add_element(64'hFFF0_0000_0000_0000);
      add_element(64'h3FF0_0000_0000_0000);
      add_element(64'h7FEF_FFFF_FFFF_FFFF);
      add_element(64'h7FEF_FFFF_FFFF_FFFF);
      add_element(64'h0000_0000_0000_0001);

      // Reduce across rows; rank 0 and extent 0 read as 1.
      set_shape(2, 2, 3, 1, 1, 1);
      push_elements(6);
      set_shape(0, 0, 5, 5, 5, 0);
      push_elements(2);
      // Rank above the top acts as 4; reduce the outermost axis.
      set_shape(7, 2, 1, 1, 2, 3);
      push_elements(4);
      // Reduced axis at or above rank: each element stands alone.
      set_shape(2, 2, 1, 9, 9, 3);
      push_elements(3);

      // A write to an unused index must not restart the tensor.
      set_shape(1, 4, 1, 1, 1, 0);
      push_elements(2);
      wait_idle();
      csr_write(CSR_NONE, 13'h1FFF);
      push_elements(2);

      // Oversized extent clamps to 4096, so the inner product just fits.
      set_shape(2, 8191, 1, 1, 1, 1);
      push_elements(8);
      // Inner product 65*64 overflows the accumulator: every sum is flagged.
      set_shape(3, 65, 64, 1, 1, 2);
      push_elements(16);

      // Random shapes, mostly small; now and then a tensor is cut short.
      sent = 0;
      while (sent < 560) begin
         rank = $urandom_range(1, 4);
         for (int d = 0; d < 4; d++) ext[d] = $urandom_range(1, 5);
         if ($urandom_range(0, 9) == 0) ext[$urandom_range(0, 3)] = $urandom_range(0, 12);
         axis = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(0, rank - 1);
         if (sent > 450) quiet = 1'b1;
         set_shape(rank, ext[0], ext[1], ext[2], ext[3], axis);
         volume = 1;
         for (int d = 0; d < rank; d++) volume *= (ext[d] == 0) ? 1 : ext[d];
         volume *= $urandom_range(1, 2);
         if ($urandom_range(0, 7) == 0) volume = $urandom_range(1, volume);
         if (volume > 600 - sent) volume = 600 - sent;
         push_elements(volume);
         sent += volume;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
rtl/tar_pkg.sv
rtl/tar_if.sv
rtl/tar_front.sv
rtl/tar_queue.sv
rtl/tar_back.sv
rtl/tensor_axis_reduce_sum.sv
sim/tensor_axis_reduce_sum_test.sv
